[rtl/lrt_pkg.sv]
// Shared constants, types and a helper function of the route table.
package lrt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = 32;
    localparam int PLEN_W  = 6;
    localparam int IFACE_W = 4;
    localparam int COST_W  = 32;

    localparam logic [PLEN_W-1:0] HOST_PLEN = 6'd32;
    localparam logic [ADDR_W-1:0] ALL_ONES  = 32'hffff_ffff;
    localparam logic [ADDR_W-1:0] MCAST_MASK = 32'hffff_ff00;
    localparam logic [ADDR_W-1:0] MCAST_NET  = 32'he000_0000;

    localparam logic [2:0] CMD_LOOKUP     = 3'd0;
    localparam logic [2:0] CMD_ADD        = 3'd1;
    localparam logic [2:0] CMD_REMOVE_IF  = 3'd2;
    localparam logic [2:0] CMD_REMOVE_NET = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DUP   = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  net;
        logic [PLEN_W-1:0]  plen;
        logic [ADDR_W-1:0]  gw;
        logic [IFACE_W-1:0] iface;
        logic [COST_W-1:0]  cost;
    } entry_t;

    typedef struct packed {
        logic   have;
        logic   done;
        entry_t ent;
    } best_t;

    typedef struct packed {
        entry_t            ent;
        logic [ADDR_W-1:0] netw;
        logic              filter_en;
        logic              rm_net;
    } key_t;

    typedef struct packed {
        logic write;
        logic shift;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOKUP,
        ST_REMOVE,
        ST_DONE
    } state_t;

    function automatic logic [ADDR_W-1:0] plen_mask(input logic [PLEN_W-1:0] plen);
        logic [ADDR_W-1:0] m;
        if (plen == '0)
        begin
            m = '0;
        end
        else
        begin
            m = ALL_ONES << (HOST_PLEN - plen);
        end
        return m;
    endfunction

endpackage

[rtl/lrt_if.sv]
// Valid/ready channel interfaces for commands and results.
interface lrt_req_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    cmd;
    logic [lrt_pkg::ADDR_W-1:0]    address;
    logic [lrt_pkg::PLEN_W-1:0]    prefix_len;
    logic [lrt_pkg::ADDR_W-1:0]    next_hop;
    logic [lrt_pkg::IFACE_W-1:0]   iface;
    logic [lrt_pkg::COST_W-1:0]    cost;
    logic                          filter_en;
    logic [3:0]                    slot;

    modport source (output valid, cmd, address, prefix_len, next_hop, iface, cost,
                    filter_en, slot, input ready);
    modport sink (input valid, cmd, address, prefix_len, next_hop, iface, cost,
                  filter_en, slot, output ready);
endinterface

interface lrt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [1:0]                    status;
    logic [lrt_pkg::ADDR_W-1:0]    route_net;
    logic [lrt_pkg::PLEN_W-1:0]    route_plen;
    logic [lrt_pkg::ADDR_W-1:0]    route_gw;
    logic [lrt_pkg::IFACE_W-1:0]   route_iface;
    logic [lrt_pkg::COST_W-1:0]    route_cost;
    logic [4:0]                    entry_count;

    modport source (output valid, found, status, route_net, route_plen, route_gw,
                    route_iface, route_cost, entry_count, input ready);
    modport sink (input valid, found, status, route_net, route_plen, route_gw,
                  route_iface, route_cost, entry_count, output ready);
endinterface

[rtl/lrt_cell.sv]
// One table cell: holds an entry, compares it and passes the running best to its neighbor.
module lrt_cell (
    input  logic                       clk,
    input  logic [lrt_pkg::IDX_W-1:0]  idx,
    input  logic [lrt_pkg::CNT_W-1:0]  count,
    input  lrt_pkg::key_t              key,
    input  lrt_pkg::cell_ctl_t         ctl,
    input  lrt_pkg::entry_t            right_ent,
    input  lrt_pkg::best_t             best_in,
    input  logic                       shift_in,
    output lrt_pkg::entry_t            ent,
    output lrt_pkg::best_t             best_out,
    output logic                       dup,
    output logic                       shift_out
);
    import lrt_pkg::*;

    entry_t ent_reg;
    best_t  best_reg;
    logic   valid;
    logic   match;
    logic   filt_ok;
    logic   better;
    logic   pick;
    logic   hit;

    assign valid   = CNT_W'(idx) < count;
    assign match   = ((key.ent.net ^ ent_reg.net) & plen_mask(ent_reg.plen)) == '0;
    assign filt_ok = !key.filter_en || (ent_reg.iface == key.ent.iface);
    assign better  = !best_in.have || (ent_reg.plen > best_in.ent.plen) ||
                     ((ent_reg.plen == best_in.ent.plen) && (ent_reg.cost <= best_in.ent.cost));
    assign pick    = valid && match && filt_ok && !best_in.done && better;

    assign hit = valid && (ent_reg.iface == key.ent.iface) &&
                 (!key.rm_net || ((ent_reg.plen != HOST_PLEN) && (ent_reg.net == key.netw) &&
                                  (ent_reg.plen == key.ent.plen)));
    assign shift_out = shift_in || hit;
    assign dup       = valid && (ent_reg == key.ent);

    always_ff @(posedge clk)
    begin
        if (ctl.write && (CNT_W'(idx) == count))
        begin
            ent_reg <= key.ent;
        end
        else if (ctl.shift && shift_out)
        begin
            ent_reg <= right_ent;
        end
        if (pick)
        begin
            best_reg.have <= 1'b1;
            best_reg.done <= (ent_reg.plen == HOST_PLEN);
            best_reg.ent  <= ent_reg;
        end
        else
        begin
            best_reg <= best_in;
        end
    end

    assign ent      = ent_reg;
    assign best_out = best_reg;

endmodule

[rtl/lpm_route_table.sv]
// Top level of the ordered IPv4 longest-prefix-match route table.
// Commands arrive one at a time. Add, read and unknown commands pass from
// the execute state to the done state; a non-multicast lookup also walks the
// lookup state, as the running best match travels one cell per cycle down the
// row of DEPTH cells; a remove stays in the remove state while the row
// closes one gap per cycle by shifting the later entries toward the front.
// A new command is taken only after the previous result has been computed.
module lpm_route_table (
    input  logic      clk,
    input  logic      rst_n,
    lrt_req_if.sink   req,
    lrt_rsp_if.source rsp
);
    import lrt_pkg::*;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [2:0]         op_reg, op_next;
    logic [3:0]         slot_reg, slot_next;
    key_t               key_reg, key_next;
    logic               res_found_reg, res_found_next;
    logic [1:0]         res_status_reg, res_status_next;
    entry_t             res_ent_reg, res_ent_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [1:0]         out_status_reg, out_status_next;
    entry_t             out_ent_reg, out_ent_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;

    cell_ctl_t          ctl;
    entry_t             ents [DEPTH];
    best_t              bests [DEPTH];
    logic [DEPTH-1:0]   dups;
    logic [DEPTH:0]     shifts;
    logic [PLEN_W-1:0]  sat_plen;
    logic               dup_any;
    logic               slot_ok;

    assign shifts[0] = 1'b0;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            best_t  b_in;
            entry_t r_ent;
            if (g == 0)
            begin : g_first
                assign b_in = '0;
            end
            else
            begin : g_rest
                assign b_in = bests[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign r_ent = ents[g];
            end
            else
            begin : g_mid
                assign r_ent = ents[g+1];
            end
            lrt_cell u_cell (
                .clk       (clk),
                .idx       (IDX_W'(g)),
                .count     (count_reg),
                .key       (key_reg),
                .ctl       (ctl),
                .right_ent (r_ent),
                .best_in   (b_in),
                .shift_in  (shifts[g]),
                .ent       (ents[g]),
                .best_out  (bests[g]),
                .dup       (dups[g]),
                .shift_out (shifts[g+1])
            );
        end
    endgenerate

    assign sat_plen = (req.prefix_len > HOST_PLEN) ? HOST_PLEN : req.prefix_len;
    assign dup_any  = |dups;
    assign slot_ok  = (int'(slot_reg) < DEPTH) && (CNT_W'(slot_reg) < count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        op_reg         <= op_next;
        slot_reg       <= slot_next;
        key_reg        <= key_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        res_ent_reg    <= res_ent_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
        out_ent_reg    <= out_ent_next;
        out_count_reg  <= out_count_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        key_next        = key_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        res_ent_next    = res_ent_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;
        out_ent_next    = out_ent_reg;
        out_count_next  = out_count_reg;
        ctl             = '0;
        req.ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    op_next            = req.cmd;
                    slot_next          = req.slot;
                    key_next.ent.net   = req.address;
                    key_next.ent.plen  = sat_plen;
                    key_next.ent.gw    = req.next_hop;
                    key_next.ent.iface = req.iface;
                    key_next.ent.cost  = req.cost;
                    key_next.netw      = req.address & plen_mask(sat_plen);
                    key_next.filter_en = req.filter_en;
                    key_next.rm_net    = (req.cmd == CMD_REMOVE_NET);
                    state_next         = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_found_next  = 1'b0;
                res_status_next = STAT_OK;
                res_ent_next    = '0;
                state_next      = ST_DONE;
                case (op_reg)
                    CMD_LOOKUP:
                    begin
                        if ((key_reg.ent.net & MCAST_MASK) == MCAST_NET)
                        begin
                            res_found_next     = 1'b1;
                            res_ent_next.net   = key_reg.ent.net;
                            res_ent_next.plen  = HOST_PLEN;
                            res_ent_next.iface = key_reg.filter_en ? key_reg.ent.iface : '0;
                        end
                        else
                        begin
                            step_next  = '0;
                            state_next = ST_LOOKUP;
                        end
                    end
                    CMD_ADD:
                    begin
                        if (dup_any)
                        begin
                            res_status_next = STAT_DUP;
                        end
                        else if (int'(count_reg) >= DEPTH)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ctl.write  = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    CMD_REMOVE_IF, CMD_REMOVE_NET:
                    begin
                        state_next = ST_REMOVE;
                    end
                    CMD_READ:
                    begin
                        if (slot_ok)
                        begin
                            res_found_next = 1'b1;
                            res_ent_next   = ents[IDX_W'(slot_reg)];
                        end
                        else
                        begin
                            res_status_next = STAT_EMPTY;
                        end
                    end
                    default:
                    begin
                        res_found_next = 1'b0;
                    end
                endcase
            end
            ST_LOOKUP:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == CNT_W'(DEPTH - 1))
                begin
                    res_found_next = bests[DEPTH-1].have;
                    res_ent_next   = bests[DEPTH-1].have ? bests[DEPTH-1].ent : '0;
                    state_next     = ST_DONE;
                end
            end
            ST_REMOVE:
            begin
                ctl.shift = 1'b1;
                if (shifts[DEPTH])
                begin
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_found_next  = res_found_reg;
                    out_status_next = res_status_reg;
                    out_ent_next    = res_ent_reg;
                    out_count_next  = count_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.route_net   = out_ent_reg.net;
    assign rsp.route_plen  = out_ent_reg.plen;
    assign rsp.route_gw    = out_ent_reg.gw;
    assign rsp.route_iface = out_ent_reg.iface;
    assign rsp.route_cost  = out_ent_reg.cost;
    assign rsp.entry_count = 5'(out_count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= DEPTH)
        else $error("entry count exceeds table depth");

    a_remove_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REMOVE && shifts[DEPTH]) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not drop exactly one entry");

    a_add_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && op_reg == CMD_ADD && !dup_any && int'(count_reg) < DEPTH)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add did not append one entry");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !req.ready)
        else $error("command taken while busy");

endmodule

[test/tb.sv]
// Self-checking testbench of lpm_route_table: random and directed commands against an internal table model.
module tb;
    import lrt_pkg::*;

    localparam logic [2:0] CMD_BAD = 3'd5;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lrt_req_if req ();
    lrt_rsp_if rsp ();

    lpm_route_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req.sink),
        .rsp(rsp.source)
    );

    typedef struct packed {
        logic              found;
        logic [1:0]        status;
        entry_t            ent;
        logic [4:0]        entry_count;
    } answer_t;

    entry_t  routes[DEPTH];
    int      route_count;
    answer_t answers[$];
    int      errors;
    int      checked;
    int      sent;
    int      lookups_hit;
    bit      stall_mode;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #400000000;
        $display("lpm_route_table test failed");
        $finish;
    end

    function automatic logic [31:0] mask_of(input logic [5:0] plen);
        return (plen == 6'd0) ? 32'h0 : (32'hffffffff << (7'd32 - plen));
    endfunction

    function automatic answer_t predict_route(input logic [2:0] cmd, input logic [31:0] addr,
        input logic [5:0] plen_in, input logic [31:0] gw, input logic [3:0] ifc,
        input logic [31:0] cost, input logic filt, input logic [3:0] slot);
        answer_t a;
        logic [5:0] plen;
        logic [5:0] best_len;
        logic [31:0] best_cost;
        logic [31:0] mk;
        bit dup;
        bit hit;
        int k;
        int m;
        a = '0;
        plen = (plen_in > 6'd32) ? 6'd32 : plen_in;
        if (cmd == CMD_LOOKUP)
        begin
            if ((addr & MCAST_MASK) == MCAST_NET)
            begin
                a.found = 1'b1;
                a.ent.net = addr;
                a.ent.plen = HOST_PLEN;
                a.ent.iface = filt ? ifc : 4'd0;
            end
            else
            begin
                best_len = 0;
                best_cost = ALL_ONES;
                for (k = 0; k < route_count; k++)
                begin
                    mk = mask_of(routes[k].plen);
                    if ((addr & mk) != (routes[k].net & mk)) continue;
                    if (filt && routes[k].iface != ifc) continue;
                    if (routes[k].plen < best_len) continue;
                    if (routes[k].plen > best_len) best_cost = ALL_ONES;
                    best_len = routes[k].plen;
                    if (routes[k].cost > best_cost) continue;
                    best_cost = routes[k].cost;
                    a.found = 1'b1;
                    a.ent = routes[k];
                    if (best_len == HOST_PLEN) break;
                end
            end
        end
        else if (cmd == CMD_ADD)
        begin
            dup = 0;
            for (k = 0; k < route_count; k++)
                if (routes[k] == {addr, plen, gw, ifc, cost}) dup = 1;
            if (dup) a.status = STAT_DUP;
            else if (route_count >= DEPTH) a.status = STAT_FULL;
            else
            begin
                routes[route_count] = {addr, plen, gw, ifc, cost};
                route_count++;
            end
        end
        else if (cmd == CMD_REMOVE_IF || cmd == CMD_REMOVE_NET)
        begin
            k = 0;
            while (k < route_count)
            begin
                hit = routes[k].iface == ifc;
                if (cmd == CMD_REMOVE_NET)
                    hit = hit && routes[k].plen != HOST_PLEN && routes[k].plen == plen
                          && routes[k].net == (addr & mask_of(plen));
                if (hit)
                begin
                    for (m = k; m + 1 < route_count; m++) routes[m] = routes[m + 1];
                    route_count--;
                end
                else k++;
            end
        end
        else if (cmd == CMD_READ)
        begin
            if (slot < route_count)
            begin
                a.found = 1'b1;
                a.ent = routes[slot];
            end
            else a.status = STAT_EMPTY;
        end
        a.entry_count = 5'(route_count);
        return a;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h expected %h (result %0d)", what, got, want, checked);
    endtask

    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] addr,
        input logic [5:0] plen, input logic [31:0] gw, input logic [3:0] ifc,
        input logic [31:0] cost, input logic filt, input logic [3:0] slot);
        answer_t a;
        a = predict_route(cmd, addr, plen, gw, ifc, cost, filt, slot);
        if (cmd == CMD_LOOKUP && a.found) lookups_hit++;
        req.valid <= 1'b1;
        req.cmd <= cmd;
        req.address <= addr;
        req.prefix_len <= plen;
        req.next_hop <= gw;
        req.iface <= ifc;
        req.cost <= cost;
        req.filter_en <= filt;
        req.slot <= slot;
        do @(posedge clk); while (!req.ready);
        answers.push_back(a);
        sent++;
        if ($urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic idle_req();
        req.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
    end

    always @(posedge clk)
    begin
        answer_t w;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (answers.size() == 0)
            begin
                report("unexpected result", 32'd1, 32'd0);
            end
            else
            begin
                w = answers.pop_front();
                if (rsp.found !== w.found) report("found", rsp.found, w.found);
                if (rsp.status !== w.status) report("status", rsp.status, w.status);
                if (rsp.route_net !== w.ent.net) report("net", rsp.route_net, w.ent.net);
                if (rsp.route_plen !== w.ent.plen) report("plen", rsp.route_plen, w.ent.plen);
                if (rsp.route_gw !== w.ent.gw) report("gw", rsp.route_gw, w.ent.gw);
                if (rsp.route_iface !== w.ent.iface)
                    report("iface", rsp.route_iface, w.ent.iface);
                if (rsp.route_cost !== w.ent.cost) report("cost", rsp.route_cost, w.ent.cost);
                if (rsp.entry_count !== w.entry_count)
                    report("count", rsp.entry_count, w.entry_count);
                checked++;
            end
        end
    end

    // Network drawn from a small pool so that lookups, duplicates and removals hit.
    function automatic logic [31:0] pool_net(input int n);
        return {8'd10, 8'(n % 4), 8'(n % 3), 8'd0};
    endfunction

    task automatic test_directed();
        send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 4'd0);
        send_cmd(CMD_LOOKUP, 32'h0a000001, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_ADD, 32'h0, 6'd0, 32'hffffffff, 4'd15, 32'hffffffff, 0, 0);
        send_cmd(CMD_ADD, 32'h0, 6'd0, 32'hffffffff, 4'd15, 32'hffffffff, 0, 0);
        send_cmd(CMD_ADD, 32'hffffffff, 6'd63, 32'h01020304, 4'd1, 32'd0, 0, 0);
        send_cmd(CMD_ADD, 32'h0a000000, 6'd8, 32'h0, 4'd2, 32'd5, 0, 0);
        send_cmd(CMD_ADD, 32'h0a000000, 6'd8, 32'h1, 4'd3, 32'd5, 0, 0);
        send_cmd(CMD_LOOKUP, 32'h0a123456, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_LOOKUP, 32'h0a123456, 0, 0, 4'd2, 0, 1'b1, 0);
        send_cmd(CMD_LOOKUP, 32'hffffffff, 0, 0, 0, 0, 0, 0);
        send_cmd(CMD_LOOKUP, 32'he00000ff, 0, 0, 4'd9, 0, 1'b1, 0);
        send_cmd(CMD_LOOKUP, 32'he0000001, 0, 0, 4'd9, 0, 1'b0, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 4'd15);
        send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 4'd1);
        send_cmd(CMD_REMOVE_NET, 32'hffffffff, 6'd32, 0, 4'd1, 0, 0, 0);
        send_cmd(CMD_REMOVE_NET, 32'h0affffff, 6'd8, 0, 4'd3, 0, 0, 0);
        send_cmd(CMD_BAD, 32'h12345678, 6'd5, 0, 4'd1, 0, 1'b1, 4'd2);
        send_cmd(3'd7, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 14; i++)
            send_cmd(CMD_ADD, pool_net(i), 6'd24, i, 4'd4, i, 0, 0);
        send_cmd(CMD_ADD, 32'h0b000000, 6'd16, 0, 4'd4, 0, 0, 0);
        send_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 4'd15);
        send_cmd(CMD_REMOVE_IF, 0, 0, 0, 4'd4, 0, 0, 0);
        send_cmd(CMD_REMOVE_IF, 0, 0, 0, 4'd15, 0, 0, 0);
        send_cmd(CMD_REMOVE_IF, 0, 0, 0, 4'd1, 0, 0, 0);
    endtask

    task automatic test_random(input int count);
        logic [2:0] cmd;
        logic [31:0] addr;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            cmd = (r < 40) ? CMD_LOOKUP : (r < 70) ? CMD_ADD : (r < 77) ? CMD_REMOVE_IF :
                  (r < 85) ? CMD_REMOVE_NET : (r < 97) ? CMD_READ : 3'($urandom_range(5, 7));
            addr = ($urandom_range(0, 3) == 0) ? $urandom :
                   (pool_net($urandom_range(0, 11)) | $urandom_range(0, 3));
            if ($urandom_range(0, 15) == 0) addr = {24'he00000, 8'($urandom)};
            send_cmd(cmd, addr,
                ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 4) * 8),
                ($urandom_range(0, 1) == 0) ? 32'h0 : $urandom,
                4'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2)),
                ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 3)) : $urandom,
                1'($urandom), 4'($urandom));
            if ($urandom_range(0, 40) == 0)
                for (int j = 0; j < 4; j++) send_cmd(CMD_REMOVE_IF, 0, 0, 0, 4'(j), 0, 0, 0);
        end
    endtask

    initial
    begin
        int wait_cycles;
        errors = 0;
        checked = 0;
        sent = 0;
        lookups_hit = 0;
        route_count = 0;
        stall_mode = 0;
        req.valid = 1'b0;
        req.cmd = CMD_LOOKUP;
        req.address = '0;
        req.prefix_len = '0;
        req.next_hop = '0;
        req.iface = '0;
        req.cost = '0;
        req.filter_en = 1'b0;
        req.slot = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(350);
        stall_mode = 1;
        test_random(650);
        idle_req();
        wait_cycles = 0;
        while (answers.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        $display("sent %0d commands, checked %0d results, %0d lookups matched a route",
                 sent, checked, lookups_hit);
        if (errors == 0 && answers.size() == 0)
            $display("lpm_route_table test passed");
        else
            $display("lpm_route_table test failed");
        $finish;
    end
endmodule
